// ----- hw/rtl/trie_pkg.sv -----
// Package for the prefix tree block: sizes of the node pool and the child-link
// store, action codes and the request structs passed to the memories.
// Depends on nothing; every other file of the block but trie_ram uses it.
package trie_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int ALPHABET   = 26;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    localparam int ACTION_W = 2;
    localparam int SYM_W    = 5;
    localparam int TOTAL_W  = 32;
    localparam int USED_W   = 11;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EXACT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd2;

    typedef struct packed {
        logic               we;
        logic [LINK_AW-1:0] waddr;
        logic [NODE_W-1:0]  wdata;
        logic               re;
        logic [LINK_AW-1:0] raddr;
    } link_req_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } mark_req_t;

endpackage

// ----- hw/rtl/trie_in_if.sv -----
// Input channel of the prefix tree block: at most one symbol of a word per item.
// Depends on trie_pkg for the field widths.
interface trie_in_if;
    logic                          valid;
    logic                          ready;
    logic [trie_pkg::ACTION_W-1:0] action;
    logic [trie_pkg::SYM_W-1:0]    symbol;
    logic                          has_symbol;
    logic                          last_symbol;

    modport source (output valid, action, symbol, has_symbol, last_symbol, input ready);
    modport sink (input valid, action, symbol, has_symbol, last_symbol, output ready);
endinterface

// ----- hw/rtl/trie_out_if.sv -----
// Result channel of the prefix tree block: one item per finished word.
// Depends on trie_pkg for the field widths.
interface trie_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         pool_overflow;
    logic [trie_pkg::TOTAL_W-1:0] total_words;
    logic [trie_pkg::USED_W-1:0]  nodes_used;

    modport source (output valid, found, pool_overflow, total_words, nodes_used, input ready);
    modport sink (input valid, found, pool_overflow, total_words, nodes_used, output ready);
endinterface

// ----- hw/rtl/trie_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Read data holds its value while no read is issued. No dependencies.
module trie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/trie_walker.sv -----
// Control of the prefix tree: clearing pass, the walk over child links, node
// allocation, word end handling and the result register.
// Depends on trie_pkg and the trie_in_if / trie_out_if interfaces.
module trie_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    trie_in_if.sink                     sym_ch,
    trie_out_if.source                  res_ch,
    output trie_pkg::link_req_t         link_req,
    input  logic [trie_pkg::NODE_W-1:0] link_rdata,
    output trie_pkg::mark_req_t         mark_req,
    input  logic                        mark_rdata
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [trie_pkg::LINK_AW-1:0]  clr_reg, clr_next;
    logic [trie_pkg::NODE_W-1:0]   walk_node_reg, walk_node_next;
    logic                          walk_failed_reg, walk_failed_next;
    logic                          walk_ovf_reg, walk_ovf_next;
    logic [trie_pkg::CNT_W-1:0]    alloc_reg, alloc_next;
    logic [trie_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [trie_pkg::ACTION_W-1:0] act_reg, act_next;
    logic                          last_reg, last_next;
    logic [trie_pkg::LINK_AW-1:0]  slot_reg, slot_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg, out_found_next;
    logic                          out_ovf_reg, out_ovf_next;
    logic [trie_pkg::TOTAL_W-1:0]  out_total_reg, out_total_next;
    logic [trie_pkg::USED_W-1:0]   out_used_reg, out_used_next;

    logic                          out_free;
    logic                          sym_ok;
    logic [trie_pkg::LINK_AW-1:0]  slot;
    logic [trie_pkg::NODE_W-1:0]   node_sel;

    assign sym_ch.ready         = (state_reg == S_IDLE);
    assign res_ch.valid         = out_valid_reg;
    assign res_ch.found         = out_found_reg;
    assign res_ch.pool_overflow = out_ovf_reg;
    assign res_ch.total_words   = out_total_reg;
    assign res_ch.nodes_used    = out_used_reg;

    assign out_free = !out_valid_reg || res_ch.ready;
    assign sym_ok   = ({{(32 - trie_pkg::SYM_W){1'b0}}, sym_ch.symbol}
                       < 32'(trie_pkg::ALPHABET));
    assign slot     = trie_pkg::LINK_AW'(walk_node_reg)
                      * trie_pkg::LINK_AW'(trie_pkg::ALPHABET)
                      + trie_pkg::LINK_AW'(sym_ch.symbol);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        walk_node_next   = walk_node_reg;
        walk_failed_next = walk_failed_reg;
        walk_ovf_next    = walk_ovf_reg;
        alloc_next       = alloc_reg;
        total_next       = total_reg;
        act_next         = act_reg;
        last_next        = last_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg;
        out_found_next   = out_found_reg;
        out_ovf_next     = out_ovf_reg;
        out_total_next   = out_total_reg;
        out_used_next    = out_used_reg;
        link_req         = '0;
        mark_req         = '0;
        node_sel         = walk_node_reg;

        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the link store; the mark store is cleared alongside it at the low addresses.
                link_req.we    = 1'b1;
                link_req.waddr = clr_reg;
                link_req.wdata = '0;
                if (clr_reg < trie_pkg::LINK_AW'(trie_pkg::NODE_COUNT))
                begin
                    mark_req.we    = 1'b1;
                    mark_req.waddr = trie_pkg::NODE_W'(clr_reg);
                    mark_req.wdata = 1'b0;
                end
                if (clr_reg == trie_pkg::LINK_AW'(trie_pkg::LINK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (sym_ch.valid)
                begin
                    act_next       = sym_ch.action;
                    last_next      = sym_ch.last_symbol;
                    mark_req.re    = 1'b1;
                    mark_req.raddr = walk_node_reg;
                    state_next     = sym_ch.last_symbol ? S_FINISH : S_IDLE;
                    if (sym_ch.has_symbol && !walk_failed_reg)
                    begin
                        if (sym_ok)
                        begin
                            link_req.re    = 1'b1;
                            link_req.raddr = slot;
                            slot_next      = slot;
                            state_next     = S_LINK;
                        end
                        else
                        begin
                            walk_failed_next = 1'b1;
                        end
                    end
                end
            end
            S_LINK:
            begin
                if (link_rdata != '0)
                begin
                    node_sel = link_rdata;
                end
                else if (act_reg != trie_pkg::ACT_INSERT)
                begin
                    walk_failed_next = 1'b1;
                end
                else if (alloc_reg >= trie_pkg::CNT_W'(trie_pkg::NODE_COUNT))
                begin
                    walk_failed_next = 1'b1;
                    walk_ovf_next    = 1'b1;
                end
                else
                begin
                    node_sel       = trie_pkg::NODE_W'(alloc_reg);
                    link_req.we    = 1'b1;
                    link_req.waddr = slot_reg;
                    link_req.wdata = trie_pkg::NODE_W'(alloc_reg);
                    alloc_next     = alloc_reg + 1'b1;
                end
                walk_node_next = node_sel;
                // The mark of the node just reached is fetched for a word end.
                mark_req.re    = 1'b1;
                mark_req.raddr = node_sel;
                state_next     = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_found_next = 1'b0;
                    out_ovf_next   = 1'b0;
                    case (act_reg)
                        trie_pkg::ACT_INSERT:
                        begin
                            if (walk_ovf_reg)
                            begin
                                out_ovf_next = 1'b1;
                            end
                            else if (!walk_failed_reg)
                            begin
                                mark_req.we    = 1'b1;
                                mark_req.waddr = walk_node_reg;
                                mark_req.wdata = 1'b1;
                                out_found_next = 1'b1;
                                if (total_reg != '1)
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                            end
                        end
                        trie_pkg::ACT_EXACT:
                        begin
                            out_found_next = !walk_failed_reg && mark_rdata;
                        end
                        default:
                        begin
                            out_found_next = !walk_failed_reg;
                        end
                    endcase
                    out_total_next   = total_next;
                    out_used_next    = trie_pkg::USED_W'(alloc_reg);
                    out_valid_next   = 1'b1;
                    walk_node_next   = '0;
                    walk_failed_next = 1'b0;
                    walk_ovf_next    = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            walk_node_reg   <= '0;
            walk_failed_reg <= 1'b0;
            walk_ovf_reg    <= 1'b0;
            alloc_reg       <= trie_pkg::CNT_W'(1);
            total_reg       <= '0;
            act_reg         <= '0;
            last_reg        <= 1'b0;
            slot_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_ovf_reg     <= 1'b0;
            out_total_reg   <= '0;
            out_used_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            walk_node_reg   <= walk_node_next;
            walk_failed_reg <= walk_failed_next;
            walk_ovf_reg    <= walk_ovf_next;
            alloc_reg       <= alloc_next;
            total_reg       <= total_next;
            act_reg         <= act_next;
            last_reg        <= last_next;
            slot_reg        <= slot_next;
            out_valid_reg   <= out_valid_next;
            out_found_reg   <= out_found_next;
            out_ovf_reg     <= out_ovf_next;
            out_total_reg   <= out_total_next;
            out_used_reg    <= out_used_next;
        end
    end

    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_reg >= trie_pkg::CNT_W'(1))
        && (alloc_reg <= trie_pkg::CNT_W'(trie_pkg::NODE_COUNT)))
        else $error("node count left its range");

    a_alloc_only_in_link: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_reg != $past(alloc_reg)) |-> ($past(state_reg) == S_LINK))
        else $error("node allocated outside a link update");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result raised without a word end");

    a_link_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        link_req.we |-> ((state_reg == S_CLEAR) || (state_reg == S_LINK)))
        else $error("unexpected child-link write");

    a_ovf_implies_fail: assert property (@(posedge clk) disable iff (!rst_n)
        walk_ovf_reg |-> walk_failed_reg)
        else $error("overflow without a failed walk");

endmodule

// ----- hw/rtl/trie_word_insert_search.sv -----
// Prefix tree with insert, exact search and prefix search; words arrive at most one
// symbol per item and a result item leaves at each marked last item. After reset the
// block sweeps its child-link and mark memories once and accepts no item meanwhile.
// A symbol item reads the child link of the current node, after which the link state
// follows it, allocates a node or marks the walk as failed. A symbol that is out of
// range, or that comes after the walk has failed, is dropped without a link read. The
// last item of a word then enters a finish state that writes or uses the accepting
// mark fetched during the walk and loads the result register; the block stays in that
// state for as long as an earlier result item waits to be accepted. An item without a
// symbol reads no child link and, if it ends the word, goes on to the finish state.
// The child-link read is the limit on the walk.
// Depends on trie_pkg, trie_in_if, trie_out_if, trie_ram and trie_walker.
module trie_word_insert_search (
    input  logic       clk,
    input  logic       rst_n,
    trie_in_if.sink    sym_ch,
    trie_out_if.source res_ch
);

    trie_pkg::link_req_t         link_req;
    trie_pkg::mark_req_t         mark_req;
    logic [trie_pkg::NODE_W-1:0] link_rdata;
    logic                        mark_rdata;

    trie_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_ch     (sym_ch),
        .res_ch     (res_ch),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .mark_req   (mark_req),
        .mark_rdata (mark_rdata)
    );

    trie_ram #(
        .WIDTH (trie_pkg::NODE_W),
        .DEPTH (trie_pkg::LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    trie_ram #(
        .WIDTH (1),
        .DEPTH (trie_pkg::NODE_COUNT)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_req.we),
        .waddr (mark_req.waddr),
        .wdata (mark_req.wdata),
        .re    (mark_req.re),
        .raddr (mark_req.raddr),
        .rdata (mark_rdata)
    );

endmodule

// ----- sim/trie_word_insert_search_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of the prefix tree block: a directed table of words, then random words.
// Uses trie_pkg, trie_in_if, trie_out_if and trie_word_insert_search.
module trie_word_insert_search_test;

    // Action 3 has no name in the package; the block treats it as a prefix search.
    localparam logic [trie_pkg::ACTION_W-1:0] ACT_UNDEF = 2'd3;

    localparam int DIRECTED_COUNT = 23;
    localparam int BANK_SIZE      = 48;
    localparam int RUN_LIMIT      = 400000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_OFF       = 400;

    typedef struct packed {
        logic [trie_pkg::ACTION_W-1:0] action;
        logic [trie_pkg::SYM_W-1:0]    symbol;
        logic                          has_symbol;
        logic                          last_symbol;
    } sym_item_t;

    typedef struct packed {
        logic                         found;
        logic                         pool_overflow;
        logic [trie_pkg::TOTAL_W-1:0] total_words;
        logic [trie_pkg::USED_W-1:0]  nodes_used;
    } word_result_t;

    typedef struct packed {
        sym_item_t    item;
        logic         typed;
        word_result_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    trie_in_if  sym_ch ();
    trie_out_if res_ch ();

    trie_word_insert_search dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sym_ch (sym_ch),
        .res_ch (res_ch)
    );

    always #2 clk = ~clk;

    // Columns: action, symbol, has_symbol, last_symbol, typed, found, overflow, total, nodes.
    dir_row_t directed_rows [DIRECTED_COUNT] = '{
        {trie_pkg::ACT_EXACT,  5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 11'd1},
        {trie_pkg::ACT_PREFIX, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 11'd1},
        {trie_pkg::ACT_INSERT, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd1, 11'd1},
        {trie_pkg::ACT_EXACT,  5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd1, 11'd1},
        {trie_pkg::ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 32'd2, 11'd2},
        {trie_pkg::ACT_INSERT, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_INSERT, 5'd24, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 32'd3, 11'd4},
        {trie_pkg::ACT_EXACT,  5'd25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_PREFIX, 5'd25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_INSERT, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd3, 11'd4},
        {trie_pkg::ACT_EXACT,  5'd26, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd3, 11'd4},
        {ACT_UNDEF,            5'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_EXACT,  5'd5,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_EXACT,  5'd7,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_INSERT, 5'd8,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_PREFIX, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_PREFIX, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_PREFIX, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_EXACT,  5'd25, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {trie_pkg::ACT_EXACT,  5'd24, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0},
        {ACT_UNDEF,            5'd31, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 11'd0}
    };

    // Shadow copy of the tree.
    bit [trie_pkg::NODE_W-1:0] link_mem [trie_pkg::LINK_DEPTH];
    bit                        accept_mark [trie_pkg::NODE_COUNT];
    int unsigned               pool_used = 1;
    bit [31:0]                 word_count = '0;
    int unsigned               walk_node = 0;
    bit                        walk_failed = 1'b0;
    bit                        walk_ovf = 1'b0;

    word_result_t predicted_results [$];

    // Words inserted so far, kept as material for searches.
    bit [4:0] bank_sym [BANK_SIZE][32];
    int       bank_len [BANK_SIZE];
    int       bank_cnt = 0;

    int  items_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  stall_left = 0;
    int  cycles_run;
    bit  pressure_done = 1'b0;
    bit  quiet = 1'b0;

    function automatic bit predict_word_result(input sym_item_t it, output word_result_t res);
        int unsigned slot;
        int unsigned nxt;
        res = '0;
        if (it.has_symbol && !walk_failed)
        begin
            if (it.symbol >= trie_pkg::ALPHABET)
                walk_failed = 1'b1;
            else
            begin
                slot = walk_node * trie_pkg::ALPHABET + it.symbol;
                nxt  = link_mem[slot];
                if (nxt == 0)
                begin
                    if (it.action != trie_pkg::ACT_INSERT)
                        walk_failed = 1'b1;
                    else if (pool_used >= trie_pkg::NODE_COUNT)
                    begin
                        walk_failed = 1'b1;
                        walk_ovf    = 1'b1;
                    end
                    else
                    begin
                        nxt = pool_used;
                        pool_used++;
                        link_mem[slot] = trie_pkg::NODE_W'(nxt);
                    end
                end
                if (!walk_failed)
                    walk_node = nxt;
            end
        end
        if (!it.last_symbol)
            return 1'b0;

        if (it.action == trie_pkg::ACT_INSERT)
        begin
            if (walk_ovf)
                res.pool_overflow = 1'b1;
            else if (!walk_failed)
            begin
                accept_mark[walk_node] = 1'b1;
                if (word_count != 32'hFFFF_FFFF)
                    word_count++;
                res.found = 1'b1;
            end
        end
        else if (it.action == trie_pkg::ACT_EXACT)
            res.found = !walk_failed && accept_mark[walk_node];
        else
            res.found = !walk_failed;
        res.total_words = word_count;
        res.nodes_used  = trie_pkg::USED_W'(pool_used);

        walk_node   = 0;
        walk_failed = 1'b0;
        walk_ovf    = 1'b0;
        return 1'b1;
    endfunction

    task automatic offer_symbol(input sym_item_t it, input bit typed,
                                input word_result_t typed_res);
        word_result_t pred;
        bit           ends_word;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sym_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.action      <= it.action;
        sym_ch.symbol      <= it.symbol;
        sym_ch.has_symbol  <= it.has_symbol;
        sym_ch.last_symbol <= it.last_symbol;
        @(posedge clk);
        while (sym_ch.ready !== 1'b1)
            @(posedge clk);
        ends_word = predict_word_result(it, pred);
        if (ends_word)
            predicted_results = {predicted_results, (typed ? typed_res : pred)};
        items_sent++;
    endtask

    // One random word. Fill mode inserts long words over the whole alphabet to use up the pool.
    task automatic random_word(input bit fill_mode);
        bit [4:0]                      w [32];
        logic [trie_pkg::ACTION_W-1:0] act;
        sym_item_t                     it;
        int                            len;
        int                            kind;
        int                            pick;
        int                            k;
        bit                            noisy;
        bit                            clean;
        kind  = (fill_mode || bank_cnt == 0) ? 0 : $urandom_range(0, 99);
        noisy = 1'b0;
        clean = 1'b1;
        act   = trie_pkg::ACT_INSERT;
        len   = 0;
        if (kind < 40)
        begin
            len = fill_mode ? $urandom_range(12, 20) : $urandom_range(1, 6);
            for (k = 0; k < len; k++)
            begin
                // A narrow alphabet makes words share prefixes, so searches hit often.
                if (fill_mode || $urandom_range(0, 9) == 0)
                    w[k] = 5'($urandom_range(0, trie_pkg::ALPHABET - 1));
                else
                    w[k] = 5'($urandom_range(0, 5));
                if (!fill_mode && $urandom_range(0, 49) == 0)
                begin
                    w[k]  = 5'($urandom_range(trie_pkg::ALPHABET, 31));
                    clean = 1'b0;
                end
            end
        end
        else if (kind < 85)
        begin
            pick = $urandom_range(0, bank_cnt - 1);
            len  = bank_len[pick];
            for (k = 0; k < len; k++)
                w[k] = bank_sym[pick][k];
            act = (kind < 65) ? trie_pkg::ACT_EXACT : trie_pkg::ACT_PREFIX;
            if (act == trie_pkg::ACT_PREFIX)
                len = $urandom_range(1, len);
            else if ($urandom_range(0, 3) == 0)
            begin
                if (len > 1 && $urandom_range(0, 1) == 1)
                    len--;
                else
                begin
                    w[len] = 5'($urandom_range(0, 5));
                    len++;
                end
            end
        end
        else if (kind < 92)
            act = trie_pkg::ACTION_W'($urandom_range(0, 3));
        else
        begin
            noisy = 1'b1;
            len   = $urandom_range(1, 5);
            for (k = 0; k < len; k++)
                w[k] = 5'($urandom_range(0, 31));
        end

        if (len == 0)
        begin
            it.action      = act;
            it.symbol      = 5'($urandom_range(0, 31));
            it.has_symbol  = 1'b0;
            it.last_symbol = 1'b1;
            offer_symbol(it, 1'b0, '0);
        end
        for (k = 0; k < len; k++)
        begin
            if (!fill_mode && $urandom_range(0, 39) == 0)
            begin
                it.action      = noisy ? trie_pkg::ACTION_W'($urandom_range(0, 3)) : act;
                it.symbol      = 5'($urandom_range(0, 31));
                it.has_symbol  = 1'b0;
                it.last_symbol = 1'b0;
                offer_symbol(it, 1'b0, '0);
            end
            it.action      = noisy ? trie_pkg::ACTION_W'($urandom_range(0, 3)) : act;
            it.symbol      = w[k];
            it.has_symbol  = 1'b1;
            it.last_symbol = (k == len - 1);
            offer_symbol(it, 1'b0, '0);
        end

        if (act == trie_pkg::ACT_INSERT && !noisy && clean && len > 0)
        begin
            pick = (bank_cnt < BANK_SIZE) ? bank_cnt : $urandom_range(0, BANK_SIZE - 1);
            if (bank_cnt < BANK_SIZE)
                bank_cnt++;
            bank_len[pick] = len;
            for (k = 0; k < len; k++)
                bank_sym[pick][k] = w[k];
        end
    endtask

    // Result side: compare, then decide whether to stall next cycle.
    always @(posedge clk)
    begin : result_check
        word_result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (predicted_results.size() == 0)
            begin
                $error("result item with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (res_ch.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, res_ch.found);
                    mismatch_count++;
                end
                if (res_ch.pool_overflow !== want.pool_overflow)
                begin
                    $error("pool_overflow: expected %0d, got %0d",
                           want.pool_overflow, res_ch.pool_overflow);
                    mismatch_count++;
                end
                if (res_ch.total_words !== want.total_words)
                begin
                    $error("total_words: expected %0d, got %0d",
                           want.total_words, res_ch.total_words);
                    mismatch_count++;
                end
                if (res_ch.nodes_used !== want.nodes_used)
                begin
                    $error("nodes_used: expected %0d, got %0d",
                           want.nodes_used, res_ch.nodes_used);
                    mismatch_count++;
                end
            end
        end
        if (stall_left != 0)
            stall_left--;
        else if (!pressure_done && results_seen >= 30)
        begin
            // Long hold-off so the block backs up and stops taking symbols.
            stall_left    = HOLD_OFF;
            pressure_done = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 13);
        res_ch.ready <= (stall_left == 0);
    end

    initial
    begin
        for (cycles_run = 0; cycles_run < RUN_LIMIT; cycles_run++)
            @(posedge clk);
        $display("trie_word_insert_search test failed");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        rst_n              <= 1'b0;
        sym_ch.valid       <= 1'b0;
        sym_ch.action      <= trie_pkg::ACT_INSERT;
        sym_ch.symbol      <= '0;
        sym_ch.has_symbol  <= 1'b0;
        sym_ch.last_symbol <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_COUNT; r++)
            offer_symbol(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);

        while (items_sent < 500)
            random_word(1'b0);
        // Use up the pool; later inserts of new words then overflow.
        r = 0;
        while (pool_used < trie_pkg::NODE_COUNT && r < 200)
        begin
            random_word(1'b1);
            r++;
        end
        while (items_sent < 1700)
            random_word(1'b0);
        quiet = 1'b1;
        while (items_sent < 1850)
            random_word(1'b0);
        sym_ch.valid <= 1'b0;

        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("trie_word_insert_search test passed");
        else
            $display("trie_word_insert_search test failed");
        $finish;
    end
endmodule
